// ----- src/battery_power_statistics_core_macros.svh -----
// Assertion helpers for the battery statistics core.
// Both expect clk and rst_n in scope at the point of use.
`ifndef BATTERY_POWER_STATISTICS_CORE_MACROS_SVH
`define BATTERY_POWER_STATISTICS_CORE_MACROS_SVH

// Same-cycle implication, held off while in reset
`define BPS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset
`define BPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bps_pkg.sv -----
package bps_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BATTERY_MIN_MV,
        REG_BATTERY_MAX_MV,
        REG_BATTERY_CAPACITY_MAH
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [15:0] RST_BATTERY_MIN_MV       = 16'd6000;
    localparam logic [15:0] RST_BATTERY_MAX_MV       = 16'd8400;
    localparam logic [15:0] RST_BATTERY_CAPACITY_MAH = 16'd2200;

    // Input beat
    typedef struct packed {
        logic        [15:0] bus_voltage_mv;
        logic signed [15:0] current_ma;
        logic        [18:0] power_mw;
        logic        [15:0] elapsed_ms;
        logic               is_moving;
    } in_t;

    // Output beat
    typedef struct packed {
        logic        [14:0] peak_current_ma;
        logic signed [15:0] idle_current_ma;
        logic signed [15:0] moving_current_ma;
        logic        [31:0] energy_uwh;
        logic        [13:0] charge_percent_x100;
        logic        [15:0] runtime_min;
    } out_t;

    // Field widths
    localparam int CUR_W     = 16;
    localparam int PEAK_W    = 15;
    localparam int PCT_W     = 14;
    localparam int RUNTIME_W = 16;
    localparam int UWH_W     = 32;
    localparam int ENERGY_W  = 64;

    // Shared serial multiplier: power x elapsed, then charge x capacity
    localparam int MUL_A_W    = 19;
    localparam int MUL_B_W    = 16;
    localparam int MUL_PROD_W = MUL_A_W + MUL_B_W;

    // Exponential average: new = trunc(9*old/10) + trunc(sample/10)
    localparam int          EMA_DIV_W     = 4;
    localparam logic [3:0]  EMA_DIVISOR   = 4'd10;
    localparam int          EMA_EXTRA_W   = 4;

    // Energy reported in uWh: mW*ms / 3600
    localparam int          UWH_DIV_W     = 12;
    localparam logic [11:0] UWH_DIVISOR   = 12'd3600;

    // Charge in hundredths of a percent
    localparam logic [13:0] PCT_FULL      = 14'd10000;
    localparam logic [13:0] PCT_ZERO      = 14'd0;
    localparam int          PCT_NUM_W     = 30;
    localparam int          PCT_DEN_W     = 16;

    // Runtime: pct * cap * 120 * 2^F / (10000 * D)
    localparam int          RT_BASE_W     = PCT_W + 16;
    localparam int          RT_SCALED_W   = RT_BASE_W + 7;
    localparam logic [15:0] RUNTIME_NO_LOAD = 16'd999;
    localparam logic [15:0] RUNTIME_SAT     = 16'hFFFF;

endpackage

// ----- src/bps_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// Quotient bits above QUO_W are folded into a sticky overflow flag.
module bps_serial_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 16,
    parameter int QUO_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quotient,
    output logic             overflow
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_sr_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             ovf_reg;
    logic [DEN_W:0]   partial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One long-division step
    assign partial  = {rem_reg, num_sr_reg[NUM_W-1]};
    assign diff     = partial - {1'b0, den_reg};
    assign fits     = (partial >= {1'b0, den_reg});
    assign rem_next = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];

    // Control and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
            if (quo_reg[QUO_W-1])
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_sr_reg <= dividend;
            den_reg    <= divisor;
            rem_reg    <= '0;
            quo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            num_sr_reg <= num_sr_reg << 1;
            rem_reg    <= rem_next;
            quo_reg    <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

// ----- src/battery_power_statistics_core.sv -----
// Battery power statistics core. Each input beat is one sensor sample; each
// one yields exactly one output beat with peak current, the idle and moving
// current averages (integer mA, fraction truncated toward zero), energy in
// uWh, charge in hundredths of a percent (linear between the min and max
// voltage registers) and a runtime estimate in minutes (999 with no load,
// saturating at 65535). The core works on one sample at a time, through
// the bit-serial datapath: the divide-by-ten average update and the charge
// divider run side by side, then the shared shift-add multiplier forms
// charge x capacity and the runtime divider works out one quotient bit per
// cycle while the energy divider runs in parallel. A finished beat sits in
// the output register, so the next sample can be taken while it waits.
// Configuration registers may only be written while the core is idle.
`include "battery_power_statistics_core_macros.svh"

module battery_power_statistics_core #(
    parameter int AVERAGE_FRACTION_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  bps_pkg::in_t                         in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output bps_pkg::out_t                        out_data
);

    localparam int F           = AVERAGE_FRACTION_BITS;
    localparam int AVG_W       = bps_pkg::CUR_W + F;
    localparam int EMA_NUM_W   = AVG_W + bps_pkg::EMA_EXTRA_W;
    localparam int PCT_NUM_W   = bps_pkg::PCT_NUM_W;
    localparam int PCT_W       = bps_pkg::PCT_W;
    localparam int MUL_A_W     = bps_pkg::MUL_A_W;
    localparam int MUL_B_W     = bps_pkg::MUL_B_W;
    localparam int MUL_PROD_W  = bps_pkg::MUL_PROD_W;
    localparam int MUL_CNT_W   = $clog2(MUL_B_W + 1);
    localparam int ENERGY_W    = bps_pkg::ENERGY_W;
    localparam int RT_BASE_W   = bps_pkg::RT_BASE_W;
    localparam int RT_SCALED_W = bps_pkg::RT_SCALED_W;
    localparam int RT_NUM_W    = RT_SCALED_W + F;
    localparam int RT_DEN_W    = AVG_W + PCT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEASURE,
        ST_UPDATE,
        ST_RT_MUL,
        ST_RT_START,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PCT_EMPTY,
        PCT_FULL_SCALE,
        PCT_DIVIDE
    } pct_mode_t;

    state_t             state_reg;
    bps_pkg::out_t      out_data_reg;
    logic               out_valid_reg;

    // Configuration
    logic [15:0]        min_mv_reg;
    logic [15:0]        max_mv_reg;
    logic [15:0]        cap_reg;

    // Statistics state
    logic [bps_pkg::PEAK_W-1:0] peak_reg;
    logic signed [AVG_W-1:0]    idle_avg_reg;
    logic signed [AVG_W-1:0]    moving_avg_reg;
    logic [ENERGY_W-1:0]        energy_reg;

    // Per-sample latches
    logic signed [15:0] cur_reg;
    logic               moving_reg;
    logic               sgn_a_reg;
    logic               sgn_s_reg;
    pct_mode_t          pct_mode_reg;
    logic               no_load_reg;

    // Shared serial multiplier
    logic [MUL_A_W-1:0]    mul_a_reg;
    logic [MUL_B_W-1:0]    mul_b_sr_reg;
    logic [MUL_PROD_W-1:0] mul_prod_reg;
    logic [MUL_CNT_W-1:0]  mul_cnt_reg;

    logic accept;
    logic load_out;

    // Sample and average seeding
    logic signed [AVG_W-1:0] sample_q;
    logic signed [AVG_W-1:0] sel_avg;
    logic signed [AVG_W-1:0] seed_avg;
    logic [AVG_W-1:0]        seed_mag;
    logic [AVG_W-1:0]        sample_mag;
    logic [EMA_NUM_W-1:0]    ema_a_num;
    logic [EMA_NUM_W-1:0]    ema_s_num;

    // Charge set-up
    logic                    pct_ge_max;
    logic                    pct_le_min;
    logic [PCT_NUM_W-1:0]    pct_num;
    logic [15:0]             pct_den;
    logic [PCT_W-1:0]        pct_val;

    // Average update and energy
    logic signed [AVG_W:0]   term_a;
    logic signed [AVG_W:0]   term_s;
    logic signed [AVG_W:0]   avg_sum;
    logic signed [AVG_W-1:0] avg_next;
    logic [ENERGY_W:0]       energy_sum;
    logic [ENERGY_W-1:0]     energy_next;

    // Runtime
    logic signed [AVG_W-1:0] sample_lat;
    logic signed [AVG_W:0]   d_full;
    logic                    no_load;
    logic [RT_SCALED_W-1:0]  rt_base;
    logic [RT_SCALED_W-1:0]  rt_scaled;
    logic [RT_NUM_W-1:0]     rt_num;
    logic [RT_DEN_W-1:0]     rt_den;
    logic [15:0]             runtime_val;

    // Divider handshakes and results
    logic                    ema_a_busy;
    logic                    ema_s_busy;
    logic [AVG_W-1:0]        ema_a_quo;
    logic [AVG_W-1:0]        ema_s_quo;
    logic                    ema_a_ovf;
    logic                    ema_s_ovf;
    logic                    pct_busy;
    logic [PCT_W-1:0]        pct_quo;
    logic                    pct_ovf;
    logic                    ediv_busy;
    logic [bps_pkg::UWH_W-1:0] ediv_quo;
    logic                    ediv_ovf;
    logic                    rt_busy;
    logic [15:0]             rt_quo;
    logic                    rt_ovf;
    logic                    rt_start;

    // Whole mA of a fixed-point average, truncated toward zero
    function automatic logic [15:0] avg_whole(input logic signed [AVG_W-1:0] a);
        logic [AVG_W-1:0] mag;
        logic [15:0]      w;
        mag = a[AVG_W-1] ? (~a + 1'b1) : a;
        w   = mag[AVG_W-1:F];
        return a[AVG_W-1] ? (~w + 1'b1) : w;
    endfunction

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    // Seed the selected average with the sample when it is exactly zero
    assign sample_q   = AVG_W'($signed(in_data.current_ma)) <<< F;
    assign sel_avg    = in_data.is_moving ? moving_avg_reg : idle_avg_reg;
    assign seed_avg   = (sel_avg == '0) ? sample_q : sel_avg;
    assign seed_mag   = seed_avg[AVG_W-1] ? (~seed_avg + 1'b1) : seed_avg;
    assign sample_mag = sample_q[AVG_W-1] ? (~sample_q + 1'b1) : sample_q;
    // Weight 9/10 on the old value: 9x as shift and add
    assign ema_a_num  = (EMA_NUM_W'(seed_mag) << 3) + EMA_NUM_W'(seed_mag);
    assign ema_s_num  = EMA_NUM_W'(sample_mag);

    // Charge range checks, in the order max then min
    assign pct_ge_max = (in_data.bus_voltage_mv >= max_mv_reg);
    assign pct_le_min = (in_data.bus_voltage_mv <= min_mv_reg);
    assign pct_num    = PCT_NUM_W'(in_data.bus_voltage_mv - min_mv_reg)
                        * PCT_NUM_W'(bps_pkg::PCT_FULL);
    assign pct_den    = max_mv_reg - min_mv_reg;

    always_comb
    begin
        case (pct_mode_reg)
            PCT_FULL_SCALE: pct_val = bps_pkg::PCT_FULL;
            PCT_DIVIDE:     pct_val = pct_quo;
            default:        pct_val = bps_pkg::PCT_ZERO;
        endcase
    end

    // Signed recombination of the two truncated quotients
    assign term_a   = sgn_a_reg ? -$signed({1'b0, ema_a_quo}) : $signed({1'b0, ema_a_quo});
    assign term_s   = sgn_s_reg ? -$signed({1'b0, ema_s_quo}) : $signed({1'b0, ema_s_quo});
    assign avg_sum  = term_a + term_s;
    assign avg_next = $signed(avg_sum[AVG_W-1:0]);

    // Saturating energy accumulate
    assign energy_sum  = {1'b0, energy_reg} + (ENERGY_W + 1)'(mul_prod_reg);
    assign energy_next = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

    // Runtime operands: D is twice the mean of sample and moving average
    assign sample_lat = AVG_W'(cur_reg) <<< F;
    assign d_full     = (AVG_W + 1)'(sample_lat) + (AVG_W + 1)'(moving_avg_reg);
    assign no_load    = cur_reg[15] || (cur_reg == '0) || d_full[AVG_W] || (d_full == '0);
    assign rt_base    = RT_SCALED_W'(mul_prod_reg[RT_BASE_W-1:0]);
    // x120 as x128 - x8
    assign rt_scaled  = (rt_base << 7) - (rt_base << 3);
    assign rt_num     = RT_NUM_W'(rt_scaled) << F;
    assign rt_den     = RT_DEN_W'(d_full[AVG_W-1:0]) * RT_DEN_W'(bps_pkg::PCT_FULL);
    assign rt_start   = (state_reg == ST_RT_START) && !no_load;

    always_comb
    begin
        if (no_load_reg)
        begin
            runtime_val = bps_pkg::RUNTIME_NO_LOAD;
        end
        else if (rt_ovf)
        begin
            runtime_val = bps_pkg::RUNTIME_SAT;
        end
        else
        begin
            runtime_val = rt_quo;
        end
    end

    // Average dividers by ten: old term and sample term side by side
    bps_serial_div #(
        .NUM_W (EMA_NUM_W),
        .DEN_W (bps_pkg::EMA_DIV_W),
        .QUO_W (AVG_W)
    ) u_ema_a_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (ema_a_num),
        .divisor  (bps_pkg::EMA_DIVISOR),
        .busy     (ema_a_busy),
        .quotient (ema_a_quo),
        .overflow (ema_a_ovf)
    );

    bps_serial_div #(
        .NUM_W (EMA_NUM_W),
        .DEN_W (bps_pkg::EMA_DIV_W),
        .QUO_W (AVG_W)
    ) u_ema_s_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (ema_s_num),
        .divisor  (bps_pkg::EMA_DIVISOR),
        .busy     (ema_s_busy),
        .quotient (ema_s_quo),
        .overflow (ema_s_ovf)
    );

    // Charge divider, only when the voltage lies strictly inside the range
    bps_serial_div #(
        .NUM_W (PCT_NUM_W),
        .DEN_W (bps_pkg::PCT_DEN_W),
        .QUO_W (PCT_W)
    ) u_pct_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && !pct_ge_max && !pct_le_min),
        .dividend (pct_num),
        .divisor  (pct_den),
        .busy     (pct_busy),
        .quotient (pct_quo),
        .overflow (pct_ovf)
    );

    // Energy to uWh
    bps_serial_div #(
        .NUM_W (ENERGY_W),
        .DEN_W (bps_pkg::UWH_DIV_W),
        .QUO_W (bps_pkg::UWH_W)
    ) u_energy_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_UPDATE),
        .dividend (energy_next),
        .divisor  (bps_pkg::UWH_DIVISOR),
        .busy     (ediv_busy),
        .quotient (ediv_quo),
        .overflow (ediv_ovf)
    );

    // Runtime divider
    bps_serial_div #(
        .NUM_W (RT_NUM_W),
        .DEN_W (RT_DEN_W),
        .QUO_W (bps_pkg::RUNTIME_W)
    ) u_rt_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .dividend (rt_num),
        .divisor  (rt_den),
        .busy     (rt_busy),
        .quotient (rt_quo),
        .overflow (rt_ovf)
    );

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg <= bps_pkg::RST_BATTERY_MIN_MV;
            max_mv_reg <= bps_pkg::RST_BATTERY_MAX_MV;
            cap_reg    <= bps_pkg::RST_BATTERY_CAPACITY_MAH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bps_pkg::REG_BATTERY_MIN_MV:       min_mv_reg <= cfg_data;
                bps_pkg::REG_BATTERY_MAX_MV:       max_mv_reg <= cfg_data;
                bps_pkg::REG_BATTERY_CAPACITY_MAH: cap_reg    <= cfg_data;
                default:                           ;
            endcase
        end
    end

    // Statistics state and per-sample control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            idle_avg_reg   <= '0;
            moving_avg_reg <= '0;
            energy_reg     <= '0;
            pct_mode_reg   <= PCT_EMPTY;
            no_load_reg    <= 1'b0;
            mul_cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (!in_data.current_ma[15] &&
                    (in_data.current_ma[bps_pkg::PEAK_W-1:0] > peak_reg))
                begin
                    peak_reg <= in_data.current_ma[bps_pkg::PEAK_W-1:0];
                end
                if (pct_ge_max)
                begin
                    pct_mode_reg <= PCT_FULL_SCALE;
                end
                else if (pct_le_min)
                begin
                    pct_mode_reg <= PCT_EMPTY;
                end
                else
                begin
                    pct_mode_reg <= PCT_DIVIDE;
                end
            end

            if (state_reg == ST_UPDATE)
            begin
                if (moving_reg)
                begin
                    moving_avg_reg <= avg_next;
                end
                else
                begin
                    idle_avg_reg <= avg_next;
                end
                energy_reg <= energy_next;
            end

            if (state_reg == ST_RT_START)
            begin
                no_load_reg <= no_load;
            end

            // Multiplier step count
            if (accept || (state_reg == ST_UPDATE))
            begin
                mul_cnt_reg <= MUL_CNT_W'(MUL_B_W);
            end
            else if (mul_cnt_reg != '0)
            begin
                mul_cnt_reg <= mul_cnt_reg - 1'b1;
            end
        end
    end

    // Sample latches and multiplier datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg      <= in_data.current_ma;
            moving_reg   <= in_data.is_moving;
            sgn_a_reg    <= seed_avg[AVG_W-1];
            sgn_s_reg    <= sample_q[AVG_W-1];
            mul_a_reg    <= in_data.power_mw;
            mul_b_sr_reg <= in_data.elapsed_ms;
            mul_prod_reg <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            mul_a_reg    <= MUL_A_W'(pct_val);
            mul_b_sr_reg <= cap_reg;
            mul_prod_reg <= '0;
        end
        else if (mul_cnt_reg != '0)
        begin
            // MSB-first shift and add
            mul_prod_reg <= (mul_prod_reg << 1)
                            + (mul_b_sr_reg[MUL_B_W-1] ? MUL_PROD_W'(mul_a_reg) : '0);
            mul_b_sr_reg <= mul_b_sr_reg << 1;
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg                     <= 1'b1;
                out_data_reg.peak_current_ma      <= peak_reg;
                out_data_reg.idle_current_ma      <= avg_whole(idle_avg_reg);
                out_data_reg.moving_current_ma    <= avg_whole(moving_avg_reg);
                out_data_reg.energy_uwh           <= ediv_ovf ? '1 : ediv_quo;
                out_data_reg.charge_percent_x100  <= pct_val;
                out_data_reg.runtime_min          <= runtime_val;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MEASURE;
                    end
                end
                ST_MEASURE:
                begin
                    if (!ema_a_busy && !ema_s_busy && !pct_busy && (mul_cnt_reg == '0))
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_RT_MUL;
                end
                ST_RT_MUL:
                begin
                    if (mul_cnt_reg == '0)
                    begin
                        state_reg <= ST_RT_START;
                    end
                end
                ST_RT_START:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!ediv_busy && !rt_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `BPS_ASSERT_IMPLY(a_ema_quotient_fits, state_reg == ST_UPDATE, !ema_a_ovf && !ema_s_ovf, "average quotient overflow")
    `BPS_ASSERT_IMPLY(a_pct_in_range, (state_reg == ST_UPDATE) && (pct_mode_reg == PCT_DIVIDE), !pct_ovf && (pct_quo < bps_pkg::PCT_FULL), "charge quotient out of range")
    `BPS_ASSERT_IMPLY(a_avg_no_wrap, state_reg == ST_UPDATE, avg_sum[AVG_W] == avg_sum[AVG_W-1], "average update wrapped")
    `BPS_ASSERT_NEXT(a_energy_div_running, state_reg == ST_UPDATE, ediv_busy, "energy divider not started")
    `BPS_ASSERT_IMPLY(a_units_idle_at_result, state_reg == ST_DONE, !ediv_busy && !rt_busy && (mul_cnt_reg == '0), "result ready with a unit still busy")

endmodule
